FILE: hdl/irph_pkg.sv
// Shared constants, types and the ratio coder for the IR pulse pattern hasher.
package irph_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int MIN_HASH_LEN      = 6;

  localparam int CFG_W = 20;
  localparam logic [CFG_W-1:0] START_GAP_RST = CFG_W'(5000);
  localparam logic [CFG_W-1:0] END_GAP_RST   = CFG_W'(10000);

  typedef enum logic [0:0] {
    REG_START_GAP = 1'b0,
    REG_END_GAP   = 1'b1
  } reg_idx_t;

  localparam logic [1:0] LEVEL_LOW  = 2'd0;
  localparam logic [1:0] LEVEL_HIGH = 2'd1;

  localparam logic [31:0] FNV_OFFSET = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME  = 32'h01000193;

  localparam logic [7:0] CODE_SHORTER = 8'd1;
  localparam logic [7:0] CODE_LONGER  = 8'd2;
  localparam logic [7:0] CODE_SIMILAR = 8'd4;

  // Compares a newer interval with the one two places earlier at a 3/4 ratio.
  function automatic logic [7:0] ratio_code(input logic [31:0] older,
                                            input logic [31:0] newer);
    logic [33:0] o4;
    logic [33:0] n4;
    logic [33:0] o3;
    logic [33:0] n3;
    o4 = {older, 2'b00};
    n4 = {newer, 2'b00};
    o3 = {2'b00, older} + {1'b0, older, 1'b0};
    n3 = {2'b00, newer} + {1'b0, newer, 1'b0};
    if (n4 < o3) begin
      return CODE_SHORTER;
    end else if (o4 < n3) begin
      return CODE_LONGER;
    end else begin
      return CODE_SIMILAR;
    end
  endfunction

endpackage

FILE: hdl/irph_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module irph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ir_pulse_pattern_hasher.sv
// Top level of the IR pulse pattern hasher: decoders, interval stores and FNV-1a walk.
// An event word that starts no hash walk is taken whenever the state machine is idle,
// so such words stream at one per cycle between walks. A closing message that must be
// hashed stalls the input while its interval store, or both in turn, is walked one read
// per cycle, and until the output register takes the hash when the walk yields one.
// Reset is synchronous and restores both gap thresholds and clears all control state.
module ir_pulse_pattern_hasher
  import irph_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // Event channel.
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [1:0]       level,
  input  logic [31:0]      tick,
  // Result channel.
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      hash,
  output logic             from_low_active,
  // Configuration write channel.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // The counter holds at most MAX_INTERVALS-1, so it doubles as the store address.
  localparam int CNT_W = $clog2(MAX_INTERVALS);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_INTERVALS - 1);
  localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(MIN_HASH_LEN);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HASH = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  logic [CFG_W-1:0] start_gap;
  logic [CFG_W-1:0] end_gap;
  logic             started;
  logic [31:0]      last_tick;
  logic [31:0]      held_hash;

  // Decoder 0 is active-high (idles low), decoder 1 is active-low (idles high).
  logic             in_msg      [2];
  logic             in_msg_next [2];
  logic [CNT_W-1:0] cnt         [2];
  logic [CNT_W-1:0] cnt_next    [2];
  logic             we          [2];
  logic             pend        [2];
  logic [31:0]      rdata       [2];

  // Hash walk.
  logic             sel_low;
  logic             low_pending;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] data_idx;
  logic             rd_v;
  logic [31:0]      w0;
  logic [31:0]      w1;
  logic [7:0]       code_q;
  logic             code_v;
  logic [31:0]      h;

  logic             accept;
  logic             is_event;
  logic             is_edge;
  logic [31:0]      gap;
  logic [CNT_W-1:0] cnt_sel;
  logic [31:0]      rd_data;
  logic             issue;
  logic             walk_done;
  logic             load_out;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign is_event  = accept && !mode && started;
  assign is_edge   = (level == LEVEL_LOW) || (level == LEVEL_HIGH);
  assign gap       = tick - last_tick;

  // Both decoders step together on each event word. Interval writes only happen
  // in the accept cycle, and the walk only reads while no word is accepted, so
  // the state machine itself is the interlock between writes and hash reads.
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      in_msg_next[d] = in_msg[d];
      cnt_next[d]    = cnt[d];
      we[d]          = 1'b0;
      pend[d]        = 1'b0;
      if (is_event) begin
        if (!in_msg[d]) begin
          if (is_edge && (level[0] == 1'(d)) && (gap > 32'(start_gap))) begin
            in_msg_next[d] = 1'b1;
            cnt_next[d]    = '0;
          end
        end else if (gap > 32'(end_gap)) begin
          in_msg_next[d] = 1'b0;
          // A message too short to hash, or one that closes while a hash is held,
          // is dropped without walking the store.
          pend[d] = (held_hash == 32'd0) && (cnt[d] >= CNT_MIN);
        end else if ((cnt[d] != CNT_FULL) && is_edge) begin
          we[d]       = 1'b1;
          cnt_next[d] = cnt[d] + CNT_W'(1);
        end
      end
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_store
    irph_ram #(
      .WIDTH(32),
      .DEPTH(MAX_INTERVALS)
    ) u_store (
      .clk  (clk),
      .we   (we[g]),
      .waddr(cnt[g]),
      .wdata(gap),
      .raddr(rd_idx),
      .rdata(rdata[g])
    );
  end

  assign cnt_sel   = sel_low ? cnt[1] : cnt[0];
  assign rd_data   = sel_low ? rdata[1] : rdata[0];
  assign issue     = (state == S_HASH) && (rd_idx != cnt_sel);
  assign walk_done = (state == S_HASH) && (rd_idx == cnt_sel) && !rd_v && !code_v;
  // The output register takes a new word when it is empty or being emptied.
  assign load_out  = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start_gap   <= START_GAP_RST;
      end_gap     <= END_GAP_RST;
      started     <= 1'b0;
      last_tick   <= '0;
      held_hash   <= '0;
      in_msg[0]   <= 1'b0;
      in_msg[1]   <= 1'b0;
      cnt[0]      <= '0;
      cnt[1]      <= '0;
      sel_low     <= 1'b0;
      low_pending <= 1'b0;
      rd_idx      <= '0;
      rd_v        <= 1'b0;
      code_v      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_START_GAP: start_gap <= cfg_data;
          REG_END_GAP:   end_gap   <= cfg_data;
          default:       ;
        endcase
      end

      in_msg[0] <= in_msg_next[0];
      in_msg[1] <= in_msg_next[1];
      cnt[0]    <= cnt_next[0];
      cnt[1]    <= cnt_next[1];

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode) begin
              held_hash <= '0;
            end else if (!started) begin
              started   <= 1'b1;
              last_tick <= tick;
            end else begin
              if (is_edge) begin
                last_tick <= tick;
              end
              // When both are pending, the active-high decoder is walked first; the active-low one
              // then only runs if the first walk leaves no hash held.
              if (pend[0] || pend[1]) begin
                state       <= S_HASH;
                sel_low     <= !pend[0];
                low_pending <= pend[0] && pend[1];
                rd_idx      <= '0;
                rd_v        <= 1'b0;
                code_v      <= 1'b0;
                h           <= FNV_OFFSET;
              end
            end
          end
        end
        S_HASH: begin
          // Stage 1: one store read per cycle.
          rd_v <= issue;
          if (issue) begin
            data_idx <= rd_idx;
            rd_idx   <= rd_idx + CNT_W'(1);
          end
          // Stage 2: a two-deep window pairs each interval with the one two back.
          code_v <= rd_v && (data_idx[CNT_W-1:1] != '0);
          if (rd_v) begin
            w0     <= rd_data;
            w1     <= w0;
            code_q <= ratio_code(w1, rd_data);
          end
          // Stage 3: FNV-1a round.
          if (code_v) begin
            h <= 32'((h ^ {24'd0, code_q}) * FNV_PRIME);
          end
          if (walk_done) begin
            if (h != 32'd0) begin
              held_hash <= h;
              state     <= S_DONE;
            end else if (low_pending) begin
              sel_low     <= 1'b1;
              low_pending <= 1'b0;
              rd_idx      <= '0;
              h           <= FNV_OFFSET;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DONE: begin
          if (load_out) begin
            hash            <= held_hash;
            from_low_active <= sel_low;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // No interval may be written while a store is being walked.
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !(we[0] || we[1]))
    else $error("interval store written during hash walk");

  // The read pointer never runs past the selected message length.
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_HASH) |-> (rd_idx <= cnt_sel))
    else $error("hash walk read pointer past message end");

  // A ratio code only follows a store read.
  a_code_after_read: assert property (@(posedge clk) disable iff (rst)
    code_v |-> $past(rd_v))
    else $error("ratio code without a preceding read");

  // A presented result is never zero.
  a_hash_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hash != 32'd0))
    else $error("zero hash presented");

endmodule
